### rtl/scbs_pkg.sv
// ----------------------------------------------------------------------------
// scbs_pkg: shared types and constants for the clipped blit span generator
// Screen geometry, strip limits, register indexes and the command/clip
// structs passed between the clipper and the span sequencer.
// ----------------------------------------------------------------------------
package scbs_pkg;

  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 240;
  localparam int MAX_STRIP_ROWS = 32;
  localparam int RESULT_LIMIT   = 32;

  // Rows actually walked per strip.
  localparam int ROW_CAP = (MAX_STRIP_ROWS < RESULT_LIMIT) ? MAX_STRIP_ROWS : RESULT_LIMIT;
  localparam int RelW    = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;

  // Configuration register indexes.
  localparam logic REG_STRIP_TOP  = 1'b0;
  localparam logic REG_STRIP_ROWS = 1'b1;

  typedef enum logic {
    OP_FILL   = 1'b0,
    OP_SPRITE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic signed [10:0] size_w;
    logic signed [10:0] size_h;
    logic [15:0]        fill_color;
  } cmd_t;

  // Horizontally clipped command with its vertical extent, before the strip.
  typedef struct packed {
    logic               sprite;
    logic               vis;
    logic [9:0]         col0;
    logic [8:0]         count;
    logic [10:0]        sx;
    logic [9:0]         w;
    logic signed [12:0] y0;
    logic signed [12:0] yend;
    logic [15:0]        color;
  } clip_t;

endpackage

### rtl/scbs_clip.sv
// ----------------------------------------------------------------------------
// scbs_clip: screen clipper
// Clips one draw command against the screen edges. A fill clips on every
// edge; a sprite only on left and right and keeps its source column.
// ----------------------------------------------------------------------------
module scbs_clip (
  input  scbs_pkg::cmd_t  cmd_i,
  output scbs_pkg::clip_t clip_o
);
  import scbs_pkg::*;

  localparam logic signed [12:0] ScrW = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] ScrH = 13'(SCREEN_HEIGHT);
  localparam logic signed [12:0] Zero = '0;

  logic signed [12:0] xs, ys, ws, hs;
  logic signed [12:0] x1, w1, y1, h1, wc, hc;
  logic signed [12:0] sx, ex, scount;
  logic               sprite, fvis, svis;

  always_comb begin
    xs = {{2{cmd_i.pos_x[10]}}, cmd_i.pos_x};
    ys = {{2{cmd_i.pos_y[10]}}, cmd_i.pos_y};
    ws = {{2{cmd_i.size_w[10]}}, cmd_i.size_w};
    hs = {{2{cmd_i.size_h[10]}}, cmd_i.size_h};
    sprite = (cmd_i.opcode == OP_SPRITE);

    // fill: pull left/top edges onto the screen, then trim right/bottom
    x1 = (xs < Zero) ? Zero : xs;
    w1 = (xs < Zero) ? ws + xs : ws;
    y1 = (ys < Zero) ? Zero : ys;
    h1 = (ys < Zero) ? hs + ys : hs;
    wc = (x1 + w1 > ScrW) ? ScrW - x1 : w1;
    hc = (y1 + h1 > ScrH) ? ScrH - y1 : h1;
    fvis = (wc > Zero) && (hc > Zero);

    // sprite: skip hidden source columns on the left, trim at the right edge
    sx     = (xs < Zero) ? -xs : Zero;
    ex     = (xs + ws > ScrW) ? ScrW - xs : ws;
    svis   = (xs < ScrW) && (ex > sx);
    scount = ex - sx;

    clip_o.sprite = sprite;
    clip_o.vis    = sprite ? svis : fvis;
    clip_o.col0   = x1[9:0];
    clip_o.count  = sprite ? scount[8:0] : wc[8:0];
    clip_o.sx     = sprite ? sx[10:0] : 11'd0;
    clip_o.w      = ws[9:0];
    clip_o.y0     = sprite ? ys : y1;
    clip_o.yend   = sprite ? ys + hs : y1 + hc;
    clip_o.color  = sprite ? 16'd0 : cmd_i.fill_color;
  end

endmodule

### rtl/scbs_span_gen.sv
// ----------------------------------------------------------------------------
// scbs_span_gen: span sequencer
// Intersects the clipped rows with the strip, seeds the first span with two
// multiplies, then walks the rows with stepping adders, one span a beat.
// ----------------------------------------------------------------------------
module scbs_span_gen (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  scbs_pkg::clip_t  clip_i,
  input  logic [9:0]       strip_top_i,
  input  logic [5:0]       strip_rows_i,
  output logic             idle_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [13:0]      dest_index_o,
  output logic [19:0]      src_offset_o,
  output logic [8:0]       pixel_count_o,
  output logic [15:0]      span_color_o,
  output logic             is_last_o
);
  import scbs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RANGE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic signed [12:0] row_q, row_d, end_q, end_d;
  logic [21:0]        prod_q, prod_d;
  logic [RelW-1:0]    rel_q, rel_d;
  logic [13:0]        dest_q, dest_d;
  logic [19:0]        src_q, src_d;
  logic               last_q, last_d;

  logic [6:0]         rows_cap;
  logic signed [12:0] top_s, strip_lim, rs, re, row_nx, rel_full;
  logic [11:0]        ydiff;

  always_comb begin
    rows_cap  = ({1'b0, strip_rows_i} > 7'(ROW_CAP)) ? 7'(ROW_CAP) : {1'b0, strip_rows_i};
    top_s     = {3'b000, strip_top_i};
    strip_lim = top_s + {6'd0, rows_cap};
    rs        = (clip_i.y0 > top_s) ? clip_i.y0 : top_s;
    re        = (clip_i.yend < strip_lim) ? clip_i.yend : strip_lim;
    row_nx    = row_q + 13'sd1;
    rel_full  = row_q - top_s;
    ydiff     = 12'(row_q - clip_i.y0);
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    end_d   = end_q;
    prod_d  = prod_q;
    rel_d   = rel_q;
    dest_d  = dest_q;
    src_d   = src_q;
    last_d  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_RANGE;
      end
      S_RANGE: begin
        row_d = rs;
        end_d = re;
        // drop commands that miss the screen or the strip
        if (!clip_i.vis || rs >= re) state_d = S_IDLE;
        else                         state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = 22'(ydiff) * 22'(clip_i.w);
        rel_d   = rel_full[RelW-1:0];
        state_d = S_LOAD;
      end
      S_LOAD: begin
        src_d   = prod_q[19:0] + 20'(clip_i.sx);
        dest_d  = 14'(rel_q) * 14'(SCREEN_WIDTH) + 14'(clip_i.col0);
        last_d  = (row_nx == end_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            // advance one row
            row_d  = row_nx;
            dest_d = dest_q + 14'(SCREEN_WIDTH);
            src_d  = src_q + 20'(clip_i.w);
            last_d = (row_nx + 13'sd1 == end_q);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    end_q  <= end_d;
    prod_q <= prod_d;
    rel_q  <= rel_d;
    dest_q <= dest_d;
    src_q  <= src_d;
    last_q <= last_d;
  end

  assign idle_o        = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_EMIT);
  assign dest_index_o  = dest_q;
  assign src_offset_o  = clip_i.sprite ? src_q : 20'd0;
  assign pixel_count_o = clip_i.count;
  assign span_color_o  = clip_i.color;
  assign is_last_o     = last_q;

endmodule

### rtl/strip_clipped_blit_spans_top.sv
// ----------------------------------------------------------------------------
// strip_clipped_blit_spans_top: clipped rectangle blit span generator
// Turns fill and sprite draw commands into per-row spans of a strip buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one draw command per beat.
//   Output channel (out_valid_o/out_ready_i) gives one span per visible row,
//   top to bottom, is_last_o set on the final span of the command.
//   A command that is clipped away entirely gives no span.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 strip_top, 1 strip_rows) at the clock edge; write only while idle.
// Timing:
//   A command passes the command and clip registers and the sequencer
//   states S_RANGE, S_MUL and S_LOAD before its first span is shown;
//   the span sequencer then walks the rows with stepping adders, one span
//   per cycle while out_ready_i is high. A fully clipped command returns
//   it to idle; in_ready_o stays low until the last span beat is taken.
// Reset clears both config registers (nothing drawn) and all sequencing.
// A stalled receiver holds the current span; the row walk waits with it.
// ----------------------------------------------------------------------------
module strip_clipped_blit_spans_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [10:0] pos_x_i,
  input  logic signed [10:0] pos_y_i,
  input  logic signed [10:0] size_w_i,
  input  logic signed [10:0] size_h_i,
  input  logic [15:0]        fill_color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [13:0]        dest_index_o,
  output logic [19:0]        src_offset_o,
  output logic [8:0]         pixel_count_o,
  output logic [15:0]        span_color_o,
  output logic               is_last_o
);
  import scbs_pkg::*;

  logic [9:0] strip_top_q;
  logic [5:0] strip_rows_q;
  cmd_t       cmd_q;
  logic       cmd_v_q;
  clip_t      clip_d, clip_q;
  logic       clip_v_q;
  logic       gen_idle;
  logic       in_fire;

  assign in_ready_o = !cmd_v_q && !clip_v_q && gen_idle;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_top_q  <= '0;
      strip_rows_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STRIP_TOP:  strip_top_q  <= cfg_data_i;
        REG_STRIP_ROWS: strip_rows_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q  <= 1'b0;
      clip_v_q <= 1'b0;
    end else begin
      cmd_v_q  <= in_fire;
      clip_v_q <= cmd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.opcode     <= opcode_e'(opcode_i);
      cmd_q.pos_x      <= pos_x_i;
      cmd_q.pos_y      <= pos_y_i;
      cmd_q.size_w     <= size_w_i;
      cmd_q.size_h     <= size_h_i;
      cmd_q.fill_color <= fill_color_i;
    end
    if (cmd_v_q) clip_q <= clip_d;
  end

  scbs_clip u_clip (
    .cmd_i  (cmd_q),
    .clip_o (clip_d)
  );

  scbs_span_gen u_span_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (clip_v_q),
    .clip_i        (clip_q),
    .strip_top_i   (strip_top_q),
    .strip_rows_i  (strip_rows_q),
    .idle_o        (gen_idle),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dest_index_o  (dest_index_o),
    .src_offset_o  (src_offset_o),
    .pixel_count_o (pixel_count_o),
    .span_color_o  (span_color_o),
    .is_last_o     (is_last_o)
  );

endmodule
